/* sv/fbmt_pkg.sv */
// shared types and constants of the file block map translator
`timescale 1ns / 1ps

package fbmt_pkg;

    localparam int ZONE_SLOTS_DEF = 10;
    localparam int Q_DEPTH        = 4;
    localparam int QAW            = $clog2(Q_DEPTH);
    localparam int QCW            = $clog2(Q_DEPTH + 1);

    localparam int ZONE_W  = 32;
    localparam int BLK_W   = 40;
    localparam int IDX_W   = 12;
    localparam int BIZ_W   = 8;
    localparam int SHIFT_W = 4;

    localparam logic [SHIFT_W-1:0] ZS_MAX = 4'd8;
    localparam logic [SHIFT_W-1:0] IS_MAX = 4'd12;

    // register reset values
    localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST    = 4'd10;
    localparam logic [SHIFT_W-1:0] ZONE_LOG2_RST      = 4'd0;
    localparam logic [SHIFT_W-1:0] DIRECT_COUNT_RST   = 4'd7;
    localparam logic [SHIFT_W-1:0] INDIRECT_SHIFT_RST = 4'd8;

    typedef enum logic [1:0] {
        CFG_BLOCK_SHIFT    = 2'd0,
        CFG_ZONE_LOG2      = 2'd1,
        CFG_DIRECT_COUNT   = 2'd2,
        CFG_INDIRECT_SHIFT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SIZE  = 2'd1,
        KIND_XLATE = 2'd2,
        KIND_REPLY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_MAPPED = 2'd0,
        ST_HOLE   = 2'd1,
        ST_PAST   = 2'd2,
        ST_FETCH  = 2'd3
    } t_status;

    // one classified result waiting for the back end
    typedef struct packed {
        t_status             status;
        logic [ZONE_W-1:0]   zone;
        logic [BIZ_W-1:0]    biz;
        logic [IDX_W-1:0]    idx;
    } t_entry;

endpackage

/* sv/fbmt_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fbmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fbmt_front.sv */
// front end: accepts beats, keeps the zone table and walk state, classifies translates
`timescale 1ns / 1ps

module fbmt_front
    import fbmt_pkg::*;
#(
    parameter int ZONE_SLOTS = ZONE_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_index,
    input  logic [SHIFT_W-1:0]   i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_kind                i_kind,
    input  logic [3:0]           i_slot,
    input  logic [ZONE_W-1:0]    i_zone_value,
    input  logic [31:0]          i_size_bytes,
    input  logic [31:0]          i_virtual_block,
    input  logic [ZONE_W-1:0]    i_entry_value,
    input  logic [QCW-1:0]       i_q_count,
    output logic                 o_push,
    output t_entry               o_entry,
    output logic [SHIFT_W-1:0]   o_zs
);

    localparam int AW = $clog2(ZONE_SLOTS);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_IND  = 2'd2
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [31:0]          r_flen;
    logic [ZONE_SLOTS-1:0] r_nz;
    logic [BIZ_W-1:0]     r_biz, n_biz;
    logic [IDX_W-1:0]     r_pend, n_pend;
    logic [SHIFT_W-1:0]   r_block_shift, r_zone_log2, r_direct_count, r_indirect_shift;

    logic                 r_s1_valid;
    t_entry               r_s1_entry;
    logic                 r_s1_ram;
    logic                 r_s1_zero;

    logic                 accept;
    logic                 push;
    t_entry               n_entry;
    logic                 use_ram;
    logic                 load_we;
    logic                 size_we;

    logic [SHIFT_W-1:0]   zs, is_eff;
    logic [46:0]          vb_bytes;
    logic                 past;
    logic [31:0]          zone, zone1, zone2;
    logic [BIZ_W-1:0]     biz;
    logic [12:0]          per;
    logic [IDX_W-1:0]     mask;
    logic                 is_direct, is_single, past2;
    logic [4:0]           rd_slot;
    logic                 rd_ok, rd_nz;
    logic [ZONE_W-1:0]    rdata;
    logic [4:0]           dc5;

    assign accept = i_valid && o_ready;
    assign o_ready = (i_q_count + QCW'(r_s1_valid)) < QCW'(Q_DEPTH);

    assign zs     = (r_zone_log2 > ZS_MAX) ? ZS_MAX : r_zone_log2;
    assign is_eff = (r_indirect_shift > IS_MAX) ? IS_MAX : r_indirect_shift;
    assign o_zs   = zs;

    assign vb_bytes = {15'd0, i_virtual_block} << r_block_shift;
    assign past     = vb_bytes >= {15'd0, r_flen};
    assign zone     = i_virtual_block >> zs;
    assign biz      = BIZ_W'(i_virtual_block & ((32'd1 << zs) - 32'd1));
    assign per      = 13'd1 << is_eff;
    assign mask     = IDX_W'(per - 13'd1);
    assign dc5      = {1'b0, r_direct_count};

    assign is_direct = zone < {28'd0, r_direct_count};
    assign zone1     = zone - {28'd0, r_direct_count};
    assign is_single = (zone1 >> is_eff) == 32'd0;
    assign zone2     = zone1 - {19'd0, per};
    // double index must stay below the entries per block
    assign past2     = (zone2 >> ({1'b0, is_eff} + {1'b0, is_eff})) != 32'd0;

    always_comb begin
        if (is_direct) begin
            rd_slot = zone[4:0];
        end else if (is_single) begin
            rd_slot = dc5;
        end else begin
            rd_slot = dc5 + 5'd1;
        end
    end

    assign rd_ok = rd_slot < 5'(ZONE_SLOTS);
    assign rd_nz = rd_ok ? r_nz[rd_slot[AW-1:0]] : 1'b0;

    always_comb begin
        n_phase         = r_phase;
        n_biz           = r_biz;
        n_pend          = r_pend;
        push            = 1'b0;
        use_ram         = 1'b0;
        load_we         = 1'b0;
        size_we         = 1'b0;
        n_entry.status  = ST_PAST;
        n_entry.zone    = '0;
        n_entry.biz     = '0;
        n_entry.idx     = '0;
        case (i_kind)
            KIND_REPLY: begin
                if (r_phase == PH_DATA) begin
                    push           = 1'b1;
                    n_entry.status = ST_MAPPED;
                    n_entry.zone   = i_entry_value;
                    n_entry.biz    = r_biz;
                    n_phase        = PH_IDLE;
                end else if (r_phase == PH_IND) begin
                    push = 1'b1;
                    if (i_entry_value == '0) begin
                        n_entry.status = ST_HOLE;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_entry.status = ST_FETCH;
                        n_entry.zone   = i_entry_value;
                        n_entry.idx    = r_pend;
                        n_phase        = PH_DATA;
                    end
                end
            end
            KIND_LOAD: begin
                load_we = (r_phase == PH_IDLE) && ({1'b0, i_slot} < 5'(ZONE_SLOTS));
            end
            KIND_SIZE: begin
                size_we = (r_phase == PH_IDLE);
            end
            KIND_XLATE: begin
                if (r_phase == PH_IDLE) begin
                    push = 1'b1;
                    if (past) begin
                        n_entry.status = ST_PAST;
                    end else begin
                        n_biz = biz;
                        if (is_direct) begin
                            // a zero direct slot maps to the block inside the zone
                            n_entry.status = ST_MAPPED;
                            n_entry.biz    = biz;
                            use_ram        = 1'b1;
                        end else if (!rd_nz) begin
                            n_entry.status = ST_HOLE;
                        end else if (is_single) begin
                            n_entry.status = ST_FETCH;
                            n_entry.idx    = zone1[IDX_W-1:0];
                            use_ram        = 1'b1;
                            n_pend         = zone1[IDX_W-1:0];
                            n_phase        = PH_DATA;
                        end else if (past2) begin
                            n_entry.status = ST_PAST;
                        end else begin
                            n_entry.status = ST_FETCH;
                            n_entry.idx    = IDX_W'(zone2 >> is_eff);
                            use_ram        = 1'b1;
                            n_pend         = zone2[IDX_W-1:0] & mask;
                            n_phase        = PH_IND;
                        end
                    end
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_flen           <= '0;
            r_nz             <= '0;
            r_biz            <= '0;
            r_pend           <= '0;
            r_block_shift    <= BLOCK_SHIFT_RST;
            r_zone_log2      <= ZONE_LOG2_RST;
            r_direct_count   <= DIRECT_COUNT_RST;
            r_indirect_shift <= INDIRECT_SHIFT_RST;
            r_s1_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLOCK_SHIFT:    r_block_shift    <= i_cfg_data;
                    CFG_ZONE_LOG2:      r_zone_log2      <= i_cfg_data;
                    CFG_DIRECT_COUNT:   r_direct_count   <= i_cfg_data;
                    CFG_INDIRECT_SHIFT: r_indirect_shift <= i_cfg_data;
                    default:            r_block_shift    <= r_block_shift;
                endcase
            end
            r_s1_valid <= accept && push;
            if (accept) begin
                r_phase <= n_phase;
                r_biz   <= n_biz;
                r_pend  <= n_pend;
                if (size_we) begin
                    r_flen <= i_size_bytes;
                end
                if (load_we) begin
                    r_nz[i_slot[AW-1:0]] <= (i_zone_value != '0);
                end
            end
        end
        r_s1_entry <= n_entry;
        r_s1_ram   <= use_ram;
        // slots never loaded, loaded with zero or beyond the table read as zero
        r_s1_zero  <= !rd_nz;
    end

    fbmt_ram #(
        .WIDTH (ZONE_W),
        .DEPTH (ZONE_SLOTS)
    ) u_zone_ram (
        .i_clk   (i_clk),
        .i_we    (accept && load_we),
        .i_waddr (i_slot[AW-1:0]),
        .i_wdata (i_zone_value),
        .i_raddr (rd_slot[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        o_entry = r_s1_entry;
        if (r_s1_ram) begin
            o_entry.zone = r_s1_zero ? '0 : rdata;
        end
    end

    assign o_push = r_s1_valid;

endmodule

/* sv/fbmt_queue.sv */
// short fifo between front and back ends
`timescale 1ns / 1ps

module fbmt_queue
    import fbmt_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_entry         i_entry,
    input  logic           i_pop,
    output logic           o_valid,
    output t_entry         o_entry,
    output logic [QCW-1:0] o_count
);

    t_entry          r_mem [Q_DEPTH];
    logic [QAW-1:0]  r_wp, r_rp;
    logic [QCW-1:0]  r_count;
    logic            do_pop;

    assign o_valid = r_count != '0;
    assign do_pop  = i_pop && o_valid;
    assign o_entry = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_count <= r_count + QCW'(i_push) - QCW'(do_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

/* sv/fbmt_back.sv */
// back end: forms the disk block and holds the output beat
`timescale 1ns / 1ps

module fbmt_back
    import fbmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_entry             i_entry,
    input  logic [SHIFT_W-1:0] i_zs,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output t_status            o_status,
    output logic [BLK_W-1:0]   o_disk_block,
    output logic [IDX_W-1:0]   o_entry_index
);

    logic               r_valid;
    t_status            r_status;
    logic [BLK_W-1:0]   r_blk;
    logic [IDX_W-1:0]   r_idx;
    logic [BLK_W-1:0]   blk;

    // hole and past end entries carry zero zone and offset
    assign blk   = ({8'd0, i_entry.zone} << i_zs) + {32'd0, i_entry.biz};
    assign o_pop = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_status <= i_entry.status;
            r_blk    <= blk;
            r_idx    <= i_entry.idx;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_disk_block  = r_blk;
    assign o_entry_index = r_idx;

endmodule

/* sv/file_block_map_translator.sv */
// top level of the file block map translator
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser: kind; tdata: load/size/translate/reply
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tuser: status; tdata: disk block, entry index
//  cfg       in   i_cfg_we                          i_cfg_index, i_cfg_data
//
// one beat per cycle in while the input is not held off; a result passes through the classify
// and zone ram read stage, the queue and the output register
// the input is held off once the queue entries plus a beat in the ram stage reach four
// synchronous active-low reset clears walk state, file size, slot flags and registers;
// the zone ram itself is not cleared, unloaded slots read as zero through the flags
`timescale 1ns / 1ps

module file_block_map_translator
    import fbmt_pkg::*;
#(
    parameter int ZONE_SLOTS = ZONE_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [3:0]    i_cfg_data,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // slot, zone_value, size_bytes, virtual_block, entry_value, zero pad
    input  logic [135:0]  i_s_axis_tdata,
    // kind
    input  logic [1:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // disk_block, entry_index, zero pad
    output logic [55:0]   o_m_axis_tdata,
    // status
    output logic [1:0]    o_m_axis_tuser
);

    logic               push;
    t_entry             f_entry;
    t_entry             q_entry;
    logic               q_valid;
    logic               q_pop;
    logic [QCW-1:0]     q_count;
    logic [SHIFT_W-1:0] zs;
    t_status            status;
    logic [BLK_W-1:0]   disk_block;
    logic [IDX_W-1:0]   entry_index;

    fbmt_front #(
        .ZONE_SLOTS (ZONE_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_kind          (t_kind'(i_s_axis_tuser)),
        .i_slot          (i_s_axis_tdata[3:0]),
        .i_zone_value    (i_s_axis_tdata[35:4]),
        .i_size_bytes    (i_s_axis_tdata[67:36]),
        .i_virtual_block (i_s_axis_tdata[99:68]),
        .i_entry_value   (i_s_axis_tdata[131:100]),
        .i_q_count       (q_count),
        .o_push          (push),
        .o_entry         (f_entry),
        .o_zs            (zs)
    );

    fbmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    fbmt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_entry       (q_entry),
        .i_zs          (zs),
        .o_pop         (q_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_status      (status),
        .o_disk_block  (disk_block),
        .o_entry_index (entry_index)
    );

    assign o_m_axis_tdata = {4'd0, entry_index, disk_block};
    assign o_m_axis_tuser = status;

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the file block map translator
`timescale 1ns / 1ps

module tb_top;
    import fbmt_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int NUM_PHASES    = 8;
    localparam int FIXED_PHASES  = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic [1:0] {
        WALK_IDLE = 2'd0,
        WALK_DATA = 2'd1,
        WALK_IND  = 2'd2
    } t_walk;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         slot;
        logic [ZONE_W-1:0]  zval;
        logic [31:0]        size;
        logic [31:0]        vblock;
        logic [ZONE_W-1:0]  entry;
    } t_beat;

    typedef struct packed {
        t_status            status;
        logic [BLK_W-1:0]   blk;
        logic [IDX_W-1:0]   idx;
    } t_answer;

    typedef struct packed {
        t_beat    beat;
        bit       known;
        t_answer  ans;
    } t_row;

    localparam t_answer NO_ANS = '0;

    // directed rows run with the reset register values: 1 KiB blocks, one block per
    // zone, seven direct slots, 256 entries per indirect block
    localparam int NUM_DIR = 26;
    localparam t_row DIR_TAB [NUM_DIR] = '{
        // empty file: everything is past the end
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{ST_PAST, 40'h0, 12'h0}},
        // reply with no walk in progress
        '{'{KIND_REPLY, 4'd0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff}, 1'b0, NO_ANS},
        '{'{KIND_SIZE, 4'd0, 32'h0, 32'hffff_ffff, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_LOAD, 4'd0, 32'hffff_ffff, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{ST_MAPPED, 40'h00_ffff_ffff, 12'h0}},
        // zero direct zone maps, it is no hole
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'h1, 32'h0}, 1'b1,
          '{ST_MAPPED, 40'h0, 12'h0}},
        // load beyond the table is ignored
        '{'{KIND_LOAD, 4'd15, 32'hdead_beef, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'd7, 32'h0}, 1'b1,
          '{ST_HOLE, 40'h0, 12'h0}},
        '{'{KIND_LOAD, 4'd7, 32'h100, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'd12, 32'h0}, 1'b1,
          '{ST_FETCH, 40'h100, 12'd5}},
        // dropped while the walk waits for its entry
        '{'{KIND_LOAD, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_SIZE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_REPLY, 4'd0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff}, 1'b1,
          '{ST_MAPPED, 40'h00_ffff_ffff, 12'h0}},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{ST_MAPPED, 40'h00_ffff_ffff, 12'h0}},
        // first double indirect block, slot still zero
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'd263, 32'h0}, 1'b1,
          '{ST_HOLE, 40'h0, 12'h0}},
        '{'{KIND_LOAD, 4'd8, 32'habcd, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANS},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'd1040, 32'h0}, 1'b1,
          '{ST_FETCH, 40'habcd, 12'd3}},
        '{'{KIND_REPLY, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{ST_HOLE, 40'h0, 12'h0}},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'd1040, 32'h0}, 1'b1,
          '{ST_FETCH, 40'habcd, 12'd3}},
        '{'{KIND_REPLY, 4'd0, 32'h0, 32'h0, 32'h0, 32'h55}, 1'b1,
          '{ST_FETCH, 40'h55, 12'd9}},
        '{'{KIND_REPLY, 4'd0, 32'h0, 32'h0, 32'h0, 32'h77}, 1'b1,
          '{ST_MAPPED, 40'h77, 12'h0}},
        // double index runs off the indirect block
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'd65799, 32'h0}, 1'b1,
          '{ST_PAST, 40'h0, 12'h0}},
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0}, 1'b1,
          '{ST_PAST, 40'h0, 12'h0}},
        '{'{KIND_SIZE, 4'd0, 32'h0, 32'd1024, 32'h0, 32'h0}, 1'b0, NO_ANS},
        // block one starts exactly at the end of a 1 KiB file
        '{'{KIND_XLATE, 4'd0, 32'h0, 32'h0, 32'd1, 32'h0}, 1'b1,
          '{ST_PAST, 40'h0, 12'h0}}
    };

    // block_shift, zone log2, direct_count, indirect_shift per phase
    localparam logic [3:0] PHASE_REGS [FIXED_PHASES][4] = '{
        '{4'd12, 4'd8,  4'd1,  4'd7},
        '{4'd10, 4'd0,  4'd8,  4'd12},
        '{4'd11, 4'd3,  4'd4,  4'd9},
        '{4'd0,  4'd15, 4'd0,  4'd15},
        '{4'd15, 4'd9,  4'd15, 4'd13},
        '{4'd10, 4'd2,  4'd9,  4'd7}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    t_beat       drv;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    // block state as the checker sees it
    logic [ZONE_W-1:0] zone_tab [ZONE_SLOTS_DEF];
    logic [31:0]       file_len;
    t_walk             walk;
    logic [BIZ_W-1:0]  biz_hold;
    logic [IDX_W-1:0]  idx_hold;
    logic [3:0]        blk_sh, zn_sh, dir_cnt, ind_sh;

    t_answer answers [$];
    t_answer got, want;
    int      misses = 0;
    int      cycles = 0;
    bit      no_gaps = 1'b0;

    always #6 i_clk = ~i_clk;

    file_block_map_translator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  ({4'b0, drv.entry, drv.vblock, drv.size, drv.zval, drv.slot}),
        .i_s_axis_tuser  (drv.kind),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    function automatic int unsigned eff_zone_log2();
        return (zn_sh > ZS_MAX) ? ZS_MAX : zn_sh;
    endfunction

    function automatic int unsigned eff_ind_shift();
        return (ind_sh > IS_MAX) ? IS_MAX : ind_sh;
    endfunction

    function automatic logic [63:0] slot_zone(input logic [63:0] s);
        return (s < ZONE_SLOTS_DEF) ? {32'h0, zone_tab[s[3:0]]} : 64'h0;
    endfunction

    // advances the block state by one beat; returns 1 when the beat gives a result
    function automatic bit map_block(input t_beat b, output t_answer a);
        logic [63:0] vb, ent, zone, per, ind;
        int unsigned zsh, ish;
        zsh = eff_zone_log2();
        ish = eff_ind_shift();
        per = 64'd1 << ish;
        vb  = {32'h0, b.vblock};
        ent = {32'h0, b.entry};
        a   = '{ST_MAPPED, '0, '0};
        if (b.kind == KIND_REPLY) begin
            if (walk == WALK_DATA) begin
                walk = WALK_IDLE;
                a = '{ST_MAPPED, 40'((ent << zsh) + biz_hold), '0};
                return 1'b1;
            end
            if (walk == WALK_IND) begin
                if (ent == 0) begin
                    walk = WALK_IDLE;
                    a = '{ST_HOLE, '0, '0};
                end else begin
                    walk = WALK_DATA;
                    a = '{ST_FETCH, 40'(ent << zsh), idx_hold};
                end
                return 1'b1;
            end
            return 1'b0;
        end
        if (walk != WALK_IDLE)
            return 1'b0;
        if (b.kind == KIND_LOAD) begin
            if (b.slot < ZONE_SLOTS_DEF)
                zone_tab[b.slot] = b.zval;
            return 1'b0;
        end
        if (b.kind == KIND_SIZE) begin
            file_len = b.size;
            return 1'b0;
        end
        if ((vb << blk_sh) >= {32'h0, file_len}) begin
            a = '{ST_PAST, '0, '0};
            return 1'b1;
        end
        zone = vb >> zsh;
        biz_hold = BIZ_W'(vb & ((64'd1 << zsh) - 1));
        if (zone < dir_cnt) begin
            a = '{ST_MAPPED, 40'((slot_zone(zone) << zsh) + biz_hold), '0};
            return 1'b1;
        end
        zone = zone - dir_cnt;
        if (zone < per) begin
            ind = slot_zone({60'h0, dir_cnt});
            if (ind == 0) begin
                a = '{ST_HOLE, '0, '0};
                return 1'b1;
            end
            walk = WALK_DATA;
            idx_hold = IDX_W'(zone);
            a = '{ST_FETCH, 40'(ind << zsh), IDX_W'(zone)};
            return 1'b1;
        end
        ind = slot_zone({60'h0, dir_cnt} + 1);
        if (ind == 0) begin
            a = '{ST_HOLE, '0, '0};
            return 1'b1;
        end
        zone = zone - per;
        if ((zone >> ish) >= per) begin
            a = '{ST_PAST, '0, '0};
            return 1'b1;
        end
        idx_hold = IDX_W'(zone & (per - 1));
        walk = WALK_IND;
        a = '{ST_FETCH, 40'(ind << zsh), IDX_W'(zone >> ish)};
        return 1'b1;
    endfunction

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2:       return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    // block number aimed at one of the zone regions under the current registers
    function automatic logic [31:0] pick_block();
        logic [63:0] zone, per;
        int unsigned zsh;
        zsh = eff_zone_log2();
        per = 64'd1 << eff_ind_shift();
        case ($urandom_range(0, 4))
            0: zone = (dir_cnt == 0) ? 64'h0 : 64'($urandom_range(0, dir_cnt - 1));
            1: zone = dir_cnt + 64'($urandom_range(0, 32'(per) - 1));
            2: zone = dir_cnt + per + 64'($urandom_range(0, 32'(per * per) - 1));
            3: zone = dir_cnt + per + per * per + 64'($urandom_range(0, 3 * 32'(per)));
            default: return $urandom;
        endcase
        return 32'((zone << zsh) + $urandom_range(0, (1 << zsh) - 1));
    endfunction

    task automatic send_beat(input t_beat b, input bit known, input t_answer typed_ans);
        int      gap;
        bit      hit;
        t_answer a;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        drv = b;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        hit = map_block(b, a);
        if (known)
            answers.push_back(typed_ans);
        else if (hit)
            answers.push_back(a);
    endtask

    // sender holds off until every result is out and the pipeline has emptied
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx r, input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = r;
        i_cfg_data  = v;
        case (r)
            CFG_BLOCK_SHIFT:    blk_sh  = v;
            CFG_ZONE_LOG2:      zn_sh   = v;
            CFG_DIRECT_COUNT:   dir_cnt = v;
            CFG_INDIRECT_SHIFT: ind_sh  = v;
            default:            blk_sh  = blk_sh;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic rand_item();
        t_beat b;
        int    pick;
        b = '{kind: KIND_LOAD, slot: 4'($urandom), zval: rnd32(), size: rnd32(),
              vblock: $urandom, entry: rnd32()};
        pick = $urandom_range(0, 99);
        // mostly answer an open walk, otherwise throw in something that gets dropped
        if (walk != WALK_IDLE) begin
            if (pick < 85)
                pick = 100;
            else
                pick = $urandom_range(0, 93);
        end
        if (pick < 12) begin
            b.kind = KIND_LOAD;
            if ($urandom_range(0, 3) != 0)
                b.slot = 4'($urandom_range(0, ZONE_SLOTS_DEF - 1));
        end else if (pick < 20) begin
            b.kind = KIND_SIZE;
            if ($urandom_range(0, 2) != 0)
                b.size = 32'hffff_ffff;
        end else if (pick < 94) begin
            b.kind = KIND_XLATE;
            b.vblock = pick_block();
        end else begin
            b.kind = KIND_REPLY;
        end
        send_beat(b, 1'b0, NO_ANS);
    endtask

    task automatic note_miss(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
        misses++;
        if (misses <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
    endtask

    // result side: hold ready low at random before taking each beat
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            repeat (stall) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{t_status'(o_m_axis_tuser), o_m_axis_tdata[39:0], o_m_axis_tdata[51:40]};
            if (answers.size() == 0) begin
                note_miss("result beat with none expected, status", '0, got.status);
            end else begin
                want = answers.pop_front();
                if (got.status != want.status)
                    note_miss("status", want.status, got.status);
                if (got.blk != want.blk)
                    note_miss("disk_block", want.blk, got.blk);
                if (got.idx != want.idx)
                    note_miss("entry_index", want.idx, got.idx);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        t_beat b;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_BLOCK_SHIFT;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        drv             = '0;
        foreach (zone_tab[s])
            zone_tab[s] = '0;
        file_len = '0;
        walk     = WALK_IDLE;
        biz_hold = '0;
        idx_hold = '0;
        blk_sh   = BLOCK_SHIFT_RST;
        zn_sh    = ZONE_LOG2_RST;
        dir_cnt  = DIRECT_COUNT_RST;
        ind_sh   = INDIRECT_SHIFT_RST;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIR_TAB[k])
            send_beat(DIR_TAB[k].beat, DIR_TAB[k].known, DIR_TAB[k].ans);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            no_gaps = (ph % 3 == 1);
            for (int r = 0; r < 4; r++)
                write_reg(t_cfg_idx'(r), (ph < FIXED_PHASES) ? PHASE_REGS[ph][r]
                                                            : 4'($urandom));
            // fill the zone table and open up the file before the mixed traffic
            for (int s = 0; s < ZONE_SLOTS_DEF; s++) begin
                b = '{kind: KIND_LOAD, slot: 4'(s), zval: rnd32(), size: '0,
                      vblock: '0, entry: '0};
                send_beat(b, 1'b0, NO_ANS);
            end
            b = '{kind: KIND_SIZE, slot: '0, zval: '0, size: 32'hffff_ffff,
                  vblock: '0, entry: '0};
            send_beat(b, 1'b0, NO_ANS);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rand_item();
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    drain();
            end
            // close any open walk so the next register write finds the block idle
            while (walk != WALK_IDLE) begin
                b = '{kind: KIND_REPLY, slot: '0, zval: '0, size: '0,
                      vblock: '0, entry: rnd32()};
                send_beat(b, 1'b0, NO_ANS);
            end
            drain();
        end

        if (misses == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
sv/fbmt_pkg.sv
sv/fbmt_ram.sv
sv/fbmt_front.sv
sv/fbmt_queue.sv
sv/fbmt_back.sv
sv/file_block_map_translator.sv
sim/tb_top.sv
